>>> hw/rtl/status_led_mode_controller_core_defines.svh
// Assertion macros for the status LED mode controller.
// Used by modules that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef STATUS_LED_MODE_CONTROLLER_CORE_DEFINES_SVH
`define STATUS_LED_MODE_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SLMC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SLMC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/slmc_pkg.sv
// Shared types, codes, reset values and color helpers for the LED mode controller.
// No dependencies; imported by every module of the block.
package slmc_pkg;

    // Item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_FLAG = 1'b1;

    // Status flag ids
    localparam logic [2:0] FL_READY   = 3'd0;
    localparam logic [2:0] FL_SAVED   = 3'd1;
    localparam logic [2:0] FL_STARTED = 3'd2;
    localparam logic [2:0] FL_ARRIVED = 3'd3;
    localparam logic [2:0] FL_ARMING  = 3'd4;
    localparam logic [2:0] FL_FREADY  = 3'd5;
    localparam logic [2:0] FL_RAINBOW = 3'd6;
    localparam logic [2:0] FL_NONE    = 3'd7;

    // Display modes
    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_READY   = 3'd1;
    localparam logic [2:0] MODE_SAVED   = 3'd2;
    localparam logic [2:0] MODE_STARTED = 3'd3;
    localparam logic [2:0] MODE_ARRIVED = 3'd4;
    localparam logic [2:0] MODE_RAINBOW = 3'd5;
    localparam logic [2:0] MODE_ARMING  = 3'd6;
    localparam logic [2:0] MODE_FREADY  = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] REG_READY_COLOUR   = 3'd0;
    localparam logic [2:0] REG_ARRIVED_COLOUR = 3'd1;
    localparam logic [2:0] REG_SAVED_COLOUR   = 3'd2;
    localparam logic [2:0] REG_RAINBOW_SMOOTH = 3'd3;
    localparam logic [2:0] REG_RAINBOW_SPEED  = 3'd4;
    localparam logic [2:0] REG_RAINBOW_STEP   = 3'd5;
    localparam logic [2:0] REG_SLOW_BLINK     = 3'd6;
    localparam logic [2:0] REG_FAST_BLINK     = 3'd7;

    // Register reset values
    localparam logic [23:0] RST_READY_COLOUR   = 24'h00FF00;
    localparam logic [23:0] RST_ARRIVED_COLOUR = 24'h0000FF;
    localparam logic [23:0] RST_SAVED_COLOUR   = 24'hFFFF00;
    localparam logic        RST_RAINBOW_SMOOTH = 1'b1;
    localparam logic [15:0] RST_RAINBOW_SPEED  = 16'd20;
    localparam logic [15:0] RST_RAINBOW_STEP   = 16'd300;
    localparam logic [15:0] RST_SLOW_BLINK     = 16'd200;
    localparam logic [15:0] RST_FAST_BLINK     = 16'd100;

    localparam logic [23:0] COLOUR_BLACK = 24'h000000;

    // Color wheel segment bounds
    localparam logic [7:0] WHEEL_SEG1 = 8'd85;
    localparam logic [7:0] WHEEL_SEG2 = 8'd170;

    // Seven anchor hues of the stepped rainbow
    localparam logic [7:0] ANCHOR_HUES [7] = '{8'd0, 8'd36, 8'd72, 8'd108,
                                               8'd144, 8'd180, 8'd216};

    typedef struct packed {
        logic       kind;
        logic [2:0] flag_id;
        logic       flag_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_item;

    typedef struct packed {
        logic [23:0] ready_colour;
        logic [23:0] arrived_colour;
        logic [23:0] saved_map_colour;
        logic        rainbow_smooth;
        logic [15:0] rainbow_speed_ms;
        logic [15:0] rainbow_step_ms;
        logic [15:0] slow_blink_ms;
        logic [15:0] fast_blink_ms;
    } t_cfg;

    // Result of processing one item: valid flag and packed RGB
    typedef struct packed {
        logic        has;
        logic [23:0] colour;
    } t_step_res;

    // Three-segment color wheel, packed red/green/blue
    function automatic logic [23:0] wheel_colour(input logic [7:0] pos);
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
        logic [23:0] c;
        p = 8'd255 - pos;
        if (p < WHEEL_SEG1) begin
            t = (p << 1) + p;
            c = {8'd255 - t, 8'd0, t};
        end else if (p < WHEEL_SEG2) begin
            q = p - WHEEL_SEG1;
            t = (q << 1) + q;
            c = {8'd0, t, 8'd255 - t};
        end else begin
            q = p - WHEEL_SEG2;
            t = (q << 1) + q;
            c = {t, 8'd255 - t, 8'd0};
        end
        return c;
    endfunction

    // x mod 7 by folding octal digits (8 = 1 mod 7)
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [4:0] y;
        logic [3:0] z;
        y = 5'(x[7:6]) + 5'(x[5:3]) + 5'(x[2:0]);
        z = 4'(y[4:3]) + 4'(y[2:0]);
        if (z >= 4'd7) begin
            z = z - 4'd7;
        end
        return z[2:0];
    endfunction

    // Fixed priority display mode
    function automatic logic [2:0] resolve_mode(input logic [6:0] flags);
        logic [2:0] m;
        if (flags[FL_RAINBOW])      m = MODE_RAINBOW;
        else if (flags[FL_ARRIVED]) m = MODE_ARRIVED;
        else if (flags[FL_STARTED]) m = MODE_STARTED;
        else if (flags[FL_FREADY])  m = MODE_FREADY;
        else if (flags[FL_ARMING])  m = MODE_ARMING;
        else if (flags[FL_SAVED])   m = MODE_SAVED;
        else if (flags[FL_READY])   m = MODE_READY;
        else                        m = MODE_OFF;
        return m;
    endfunction

endpackage

>>> hw/rtl/status_led_mode_controller_core.sv
// Status LED mode controller: turns millisecond ticks and status flag updates into
// fill colors for an LED strip. One item is accepted per clock while results are
// taken; an item is processed while it sits in the input register and the output
// register is free, and its color (if any) is loaded into the output register.
// The output register lets a new item enter while a color waits to be taken.
// Configuration writes are taken every cycle (ready is always high) and must only
// happen while the block is idle.
// Depends on slmc_pkg, slmc_cfg_regs, slmc_engine and the assertion macro header.
`include "status_led_mode_controller_core_defines.svh"

module status_led_mode_controller_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  slmc_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output slmc_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);
    import slmc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      w_load_ok;
    logic      w_fire;
    t_cfg      w_cfg;
    t_step_res w_res;

    // Output register free this cycle
    assign w_load_ok  = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_load_ok;
    assign o_in_ready = !r_in_valid || w_load_ok;
    assign o_cfg_ready = 1'b1;

    slmc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    slmc_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_fire),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_ok) begin
            r_out_valid <= w_fire && w_res.has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res.has) begin
            r_out.red   <= w_res.colour[23:16];
            r_out.green <= w_res.colour[15:8];
            r_out.blue  <= w_res.colour[7:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Input side stalls only behind a held item and a blocked result
    `SLMC_ASSERT_IMP(a_stall_cause, !o_in_ready, r_in_valid && r_out_valid && !i_out_ready, "input stalled without a blocked result")
    // Raising the rainbow flag always produces an item (the wheel start color)
    `SLMC_ASSERT_NXT(a_rainbow_paint, w_fire && r_in.kind == KIND_FLAG && r_in.flag_id == FL_RAINBOW && r_in.flag_value, o_out_valid, "rainbow start produced no item")
    // Unknown flag id produces nothing
    `SLMC_ASSERT_NXT(a_unknown_flag, w_fire && r_in.kind == KIND_FLAG && r_in.flag_id == FL_NONE, !o_out_valid, "unknown flag produced an item")
    // Off mode after a flag update paints black
    `SLMC_ASSERT_NXT(a_off_black, w_fire && r_in.kind == KIND_FLAG && r_in.flag_id != FL_NONE && resolve_mode(u_engine.n_flags) == MODE_OFF, o_out_valid && o_out_item == '0, "off mode did not paint black")

endmodule

>>> hw/rtl/slmc_cfg_regs.sv
// Configuration register file of the LED mode controller.
// Depends on slmc_pkg for register indexes, reset values and t_cfg.
module slmc_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [2:0]    i_wr_index,
    input  logic [23:0]   i_wr_data,
    output slmc_pkg::t_cfg o_cfg
);
    import slmc_pkg::*;

    t_cfg r_cfg;

    // Register writes, one register per write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ready_colour     <= RST_READY_COLOUR;
            r_cfg.arrived_colour   <= RST_ARRIVED_COLOUR;
            r_cfg.saved_map_colour <= RST_SAVED_COLOUR;
            r_cfg.rainbow_smooth   <= RST_RAINBOW_SMOOTH;
            r_cfg.rainbow_speed_ms <= RST_RAINBOW_SPEED;
            r_cfg.rainbow_step_ms  <= RST_RAINBOW_STEP;
            r_cfg.slow_blink_ms    <= RST_SLOW_BLINK;
            r_cfg.fast_blink_ms    <= RST_FAST_BLINK;
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_READY_COLOUR:   r_cfg.ready_colour     <= i_wr_data;
                REG_ARRIVED_COLOUR: r_cfg.arrived_colour   <= i_wr_data;
                REG_SAVED_COLOUR:   r_cfg.saved_map_colour <= i_wr_data;
                REG_RAINBOW_SMOOTH: r_cfg.rainbow_smooth   <= i_wr_data[0];
                REG_RAINBOW_SPEED:  r_cfg.rainbow_speed_ms <= i_wr_data[15:0];
                REG_RAINBOW_STEP:   r_cfg.rainbow_step_ms  <= i_wr_data[15:0];
                REG_SLOW_BLINK:     r_cfg.slow_blink_ms    <= i_wr_data[15:0];
                REG_FAST_BLINK:     r_cfg.fast_blink_ms    <= i_wr_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/slmc_engine.sv
// Mode state and per-item logic: flag updates, blink timing, rainbow stepping.
// Depends on slmc_pkg for codes, wheel/mod7/priority functions and structs.
module slmc_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  slmc_pkg::t_in_item i_item,
    input  slmc_pkg::t_cfg     i_cfg,
    output slmc_pkg::t_step_res o_res
);
    import slmc_pkg::*;

    logic [6:0]  r_flags,  n_flags;
    logic [2:0]  r_mode,   n_mode;
    logic [31:0] r_time,   n_time;
    logic [31:0] r_blink_mark,  n_blink_mark;
    logic [31:0] r_smooth_mark, n_smooth_mark;
    logic [31:0] r_anchor_mark, n_anchor_mark;
    logic        r_blink_lit, n_blink_lit;
    logic [7:0]  r_hue, n_hue;
    logic [7:0]  r_anchor_idx, n_anchor_idx;

    logic [6:0]  w_flags_upd;
    logic [31:0] w_time_inc;
    logic [31:0] w_blink_dt;
    logic [31:0] w_smooth_dt;
    logic [31:0] w_anchor_dt;
    logic [15:0] w_blink_period;
    logic        w_fast;
    logic [7:0]  w_anchor_hue;
    logic [7:0]  w_hue_inc;
    t_step_res   w_res;

    // Elapsed times after this tick, modulo 2^32
    assign w_time_inc   = r_time + 32'd1;
    assign w_blink_dt   = w_time_inc - r_blink_mark;
    assign w_smooth_dt  = w_time_inc - r_smooth_mark;
    assign w_anchor_dt  = w_time_inc - r_anchor_mark;
    assign w_fast       = (r_mode == MODE_ARMING);
    assign w_blink_period = w_fast ? i_cfg.fast_blink_ms : i_cfg.slow_blink_ms;
    assign w_anchor_hue = ANCHOR_HUES[mod7(r_anchor_idx)];
    assign w_hue_inc    = r_hue + 8'd1;

    // Flag vector with the addressed flag replaced
    always_comb begin
        w_flags_upd = r_flags;
        if (i_item.flag_id != FL_NONE) begin
            w_flags_upd[i_item.flag_id] = i_item.flag_value;
        end
    end

    // Next state and result for the item being processed
    always_comb begin
        n_flags       = r_flags;
        n_mode        = r_mode;
        n_time        = r_time;
        n_blink_mark  = r_blink_mark;
        n_smooth_mark = r_smooth_mark;
        n_anchor_mark = r_anchor_mark;
        n_blink_lit   = r_blink_lit;
        n_hue         = r_hue;
        n_anchor_idx  = r_anchor_idx;
        w_res.has     = 1'b0;
        w_res.colour  = COLOUR_BLACK;

        if (i_item.kind == KIND_FLAG) begin
            if (i_item.flag_id != FL_NONE) begin
                n_flags = w_flags_upd;
                n_mode  = resolve_mode(w_flags_upd);
                if (i_item.flag_id == FL_RAINBOW && i_item.flag_value) begin
                    // rainbow restart: wheel from hue zero
                    n_smooth_mark = r_time;
                    n_anchor_mark = r_time;
                    n_hue         = 8'd0;
                    n_anchor_idx  = 8'd0;
                    w_res.has     = 1'b1;
                    w_res.colour  = wheel_colour(8'd0);
                end else begin
                    if (i_item.flag_value &&
                        (i_item.flag_id inside {FL_STARTED, FL_ARMING, FL_FREADY})) begin
                        n_blink_mark = r_time;
                        n_blink_lit  = 1'b1;
                    end
                    // solid and off modes paint at once
                    case (n_mode)
                        MODE_ARRIVED: begin
                            w_res.has    = 1'b1;
                            w_res.colour = i_cfg.arrived_colour;
                        end
                        MODE_SAVED: begin
                            w_res.has    = 1'b1;
                            w_res.colour = i_cfg.saved_map_colour;
                        end
                        MODE_READY: begin
                            w_res.has    = 1'b1;
                            w_res.colour = i_cfg.ready_colour;
                        end
                        MODE_OFF: begin
                            w_res.has    = 1'b1;
                            w_res.colour = COLOUR_BLACK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end else begin
            n_time = w_time_inc;
            case (r_mode)
                MODE_STARTED, MODE_FREADY, MODE_ARMING: begin
                    if (w_blink_dt >= 32'(w_blink_period)) begin
                        n_blink_mark = w_time_inc;
                        n_blink_lit  = ~r_blink_lit;
                        w_res.has    = 1'b1;
                        if (r_blink_lit) begin
                            w_res.colour = COLOUR_BLACK;
                        end else if (r_flags[FL_SAVED]) begin
                            w_res.colour = i_cfg.saved_map_colour;
                        end else if (w_fast) begin
                            w_res.colour = i_cfg.ready_colour;
                        end else begin
                            w_res.colour = i_cfg.arrived_colour;
                        end
                    end
                end
                MODE_RAINBOW: begin
                    if (i_cfg.rainbow_smooth) begin
                        if (w_smooth_dt >= 32'(i_cfg.rainbow_speed_ms)) begin
                            n_smooth_mark = w_time_inc;
                            n_hue         = w_hue_inc;
                            w_res.has     = 1'b1;
                            w_res.colour  = wheel_colour(w_hue_inc);
                        end
                    end else if (w_anchor_dt >= 32'(i_cfg.rainbow_step_ms)) begin
                        n_anchor_mark = w_time_inc;
                        n_anchor_idx  = r_anchor_idx + 8'd1;
                        w_res.has     = 1'b1;
                        w_res.colour  = wheel_colour(w_anchor_hue);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // State registers, updated only when an item is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags       <= '0;
            r_mode        <= MODE_OFF;
            r_time        <= '0;
            r_blink_mark  <= '0;
            r_smooth_mark <= '0;
            r_anchor_mark <= '0;
            r_blink_lit   <= 1'b0;
            r_hue         <= '0;
            r_anchor_idx  <= '0;
        end else if (i_step) begin
            r_flags       <= n_flags;
            r_mode        <= n_mode;
            r_time        <= n_time;
            r_blink_mark  <= n_blink_mark;
            r_smooth_mark <= n_smooth_mark;
            r_anchor_mark <= n_anchor_mark;
            r_blink_lit   <= n_blink_lit;
            r_hue         <= n_hue;
            r_anchor_idx  <= n_anchor_idx;
        end
    end

    assign o_res = w_res;

endmodule
